FILE: hw/rtl/ssec_pkg.sv
// Shared constants and types for the sprite square expand/cull core.
// No dependencies; imported by the core and its checker.
package ssec_pkg;

  localparam int TILE_PX                = 16;
  localparam int SPRITE_SLOTS           = 64;
  localparam int SQUARE_SLOTS           = 256;
  localparam int MAX_SQUARES_PER_SPRITE = 64;

  // field widths fixed by the item format
  localparam int ActionW  = 2;
  localparam int SprIdW   = 6;
  localparam int PosW     = 16;
  localparam int LayerW   = 8;
  localparam int PixW     = 12;
  localparam int SqIdW    = 8;
  localparam int CntW     = 7;
  localparam int CfgW     = 8;
  localparam int CfgIdxW  = 1;
  localparam int OutPosW  = 16;

  localparam int InDataW  = 112;
  localparam int OutDataW = 56;

  // offset table is indexed by square id modulo SQUARE_SLOTS (a power of two)
  localparam int SqAddrW  = $clog2(SQUARE_SLOTS);

  // pixel math: product of position and tile size, then coordinates with headroom
  localparam int ProdW    = PosW + $clog2(TILE_PX) + 1;
  localparam int CoordW   = PosW + $clog2(TILE_PX);

  localparam logic signed [CoordW-1:0] NegTile = CoordW'(-TILE_PX);

  // actions carried in tuser
  localparam logic [ActionW-1:0] ActPush   = 2'd0;
  localparam logic [ActionW-1:0] ActHeader = 2'd1;
  localparam logic [ActionW-1:0] ActOffset = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgViewWidth  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgViewHeight = 1'd1;

  typedef struct packed {
    logic [CntW-1:0]  count;
    logic [SqIdW-1:0] base;
    logic [PixW-1:0]  width;
  } hdr_t;

  typedef struct packed {
    logic [PixW-1:0] y;
    logic [PixW-1:0] x;
  } off_t;

  typedef struct packed {
    logic [OutPosW-1:0] x;
    logic [OutPosW-1:0] y;
    logic [SqIdW-1:0]   id;
  } sq_word_t;

endpackage

FILE: hw/rtl/sprite_square_expand_cull_core.sv
// Sprite square expansion with view culling: tables, sequencer and output stage.
// Depends on ssec_pkg.

// Header and offset writes leave the input ready. A push first looks up the
// header, then visits each square of the sprite in turn (one offset-table
// read, then one pass through the shared add/compare unit), then releases
// the final square; a visible square can wait on a stalled output register.
// A push of an unwritten slot or of a zero-count sprite ends after the header
// lookup. Squares leave through a one-word output register; one visible square
// is held back so the last one of a push can carry tlast. Both tables come up
// undefined after reset except the sprite valid bits, which reset clears.
module sprite_square_expand_cull_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [ssec_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [ssec_pkg::CfgW-1:0]       cfg_wdata_i,
  // input words
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // sprite_id[5:0] pos_x[21:6] pos_y[37:22] layer[45:38] flip[46]
  // sprite_width[58:47] square_base[66:59] square_count[73:67]
  // square_index[81:74] offset_x[93:82] offset_y[105:94], zero above
  input  logic [ssec_pkg::InDataW-1:0]    s_axis_tdata,
  // action[1:0]
  input  logic [ssec_pkg::ActionW-1:0]    s_axis_tuser,
  // result words
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // square_x[15:0] square_y[31:16] square_layer[39:32] square_id[47:40]
  // square_flip[48], zero above
  output logic [ssec_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                            m_axis_tlast
);
  import ssec_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StHdr   = 3'd1;
  localparam logic [2:0] StFetch = 3'd2;
  localparam logic [2:0] StEval  = 3'd3;
  localparam logic [2:0] StFlush = 3'd4;

  // input field unpack
  logic [SprIdW-1:0]       in_id;
  logic signed [PosW-1:0]  in_pos_x, in_pos_y;
  logic [LayerW-1:0]       in_layer;
  logic                    in_flip;
  logic [PixW-1:0]         in_width;
  logic [SqIdW-1:0]        in_base;
  logic [CntW-1:0]         in_count;
  logic [SqIdW-1:0]        in_sq_index;
  logic [PixW-1:0]         in_off_x, in_off_y;

  assign in_id       = s_axis_tdata[5:0];
  assign in_pos_x    = s_axis_tdata[21:6];
  assign in_pos_y    = s_axis_tdata[37:22];
  assign in_layer    = s_axis_tdata[45:38];
  assign in_flip     = s_axis_tdata[46];
  assign in_width    = s_axis_tdata[58:47];
  assign in_base     = s_axis_tdata[66:59];
  assign in_count    = s_axis_tdata[73:67];
  assign in_sq_index = s_axis_tdata[81:74];
  assign in_off_x    = s_axis_tdata[93:82];
  assign in_off_y    = s_axis_tdata[105:94];

  logic [2:0] state_q, state_d;
  logic       in_acc;

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // ---------------- configuration ----------------
  logic [CfgW-1:0] view_w_q, view_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_w_q <= CfgW'(20);
      view_h_q <= CfgW'(15);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgViewWidth:  view_w_q <= cfg_wdata_i;
        CfgViewHeight: view_h_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------- tables ----------------
  logic [SPRITE_SLOTS-1:0] spr_valid_q;
  hdr_t                    hdr_mem [SPRITE_SLOTS];
  off_t                    off_mem [SQUARE_SLOTS];
  hdr_t                    hdr_rd_q;
  off_t                    off_rd_q;
  logic [CntW-1:0]         cnt_sat;
  logic                    hdr_wr, off_wr;

  assign cnt_sat = (int'(in_count) > MAX_SQUARES_PER_SPRITE) ?
                   CntW'(MAX_SQUARES_PER_SPRITE) : in_count;
  assign hdr_wr  = in_acc && (s_axis_tuser == ActHeader) && (int'(in_id) < SPRITE_SLOTS);
  assign off_wr  = in_acc && (s_axis_tuser == ActOffset) && (int'(in_sq_index) < SQUARE_SLOTS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spr_valid_q <= '0;
    end else if (hdr_wr) begin
      spr_valid_q[in_id] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (hdr_wr) begin
      hdr_mem[in_id] <= '{count: cnt_sat, base: in_base, width: in_width};
    end
    if (state_q == StIdle) begin
      hdr_rd_q <= hdr_mem[in_id];
    end
  end

  logic [SqIdW-1:0] sq_q, sq_d;

  always_ff @(posedge clk_i) begin
    if (off_wr) begin
      off_mem[in_sq_index[SqAddrW-1:0]] <= '{y: in_off_y, x: in_off_x};
    end
    if (state_q == StFetch) begin
      off_rd_q <= off_mem[sq_q[SqAddrW-1:0]];
    end
  end

  // ---------------- position to pixels (truncate toward zero) ----------------
  logic signed [ProdW-1:0]  prod_x, prod_y, bias_x, bias_y;
  logic signed [CoordW-1:0] pix_x, pix_y;

  assign prod_x = ProdW'(in_pos_x) * $signed(ProdW'(TILE_PX));
  assign prod_y = ProdW'(in_pos_y) * $signed(ProdW'(TILE_PX));
  assign bias_x = prod_x[ProdW-1] ? ProdW'(15) : '0;
  assign bias_y = prod_y[ProdW-1] ? ProdW'(15) : '0;
  assign pix_x  = CoordW'((prod_x + bias_x) >>> 4);
  assign pix_y  = CoordW'((prod_y + bias_y) >>> 4);

  // ---------------- per-push registers ----------------
  logic                     hit_q;
  logic signed [CoordW-1:0] px0_q, py0_q, basex_q, basex_d;
  logic [LayerW-1:0]        layer_q;
  logic                     flip_q;
  logic [CntW-1:0]          cnt_q, cnt_d, idx_q, idx_d;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px0_q   <= pix_x;
      py0_q   <= pix_y;
      layer_q <= in_layer;
      flip_q  <= in_flip;
    end
    basex_q <= basex_d;
    cnt_q   <= cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (in_acc) begin
      hit_q <= (s_axis_tuser == ActPush) && (int'(in_id) < SPRITE_SLOTS) && spr_valid_q[in_id];
    end
  end

  // ---------------- shared add/compare unit ----------------
  logic signed [CoordW-1:0] lim_x, lim_y, ofs_x, ofs_y, cur_x, cur_y;
  logic                     visible;

  assign lim_x   = CoordW'((int'(view_w_q) + 1) * TILE_PX);
  assign lim_y   = CoordW'((int'(view_h_q) + 1) * TILE_PX);
  assign ofs_x   = $signed({{(CoordW-PixW){1'b0}}, off_rd_q.x});
  assign ofs_y   = $signed({{(CoordW-PixW){1'b0}}, off_rd_q.y});
  assign cur_x   = flip_q ? (basex_q - ofs_x) : (basex_q + ofs_x);
  assign cur_y   = py0_q + ofs_y;
  assign visible = (cur_x > NegTile) && (cur_x < lim_x) &&
                   (cur_y > NegTile) && (cur_y < lim_y);

  // ---------------- held square and output register ----------------
  sq_word_t         pend_q, pend_d, out_q, out_d;
  logic             pend_vld_q, pend_vld_d, out_vld_q, out_vld_d;
  logic             out_last_q, out_last_d;
  logic [LayerW-1:0] out_layer_q, out_layer_d;
  logic             out_flip_q, out_flip_d;
  logic             out_free;

  assign out_free = !out_vld_q || m_axis_tready;

  always_comb begin
    state_d     = state_q;
    sq_d        = sq_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    basex_d     = basex_q;
    pend_d      = pend_q;
    pend_vld_d  = pend_vld_q;
    out_d       = out_q;
    out_last_d  = out_last_q;
    out_layer_d = out_layer_q;
    out_flip_d  = out_flip_q;
    out_vld_d   = out_vld_q && !m_axis_tready;

    case (state_q)
      StIdle: begin
        if (in_acc && (s_axis_tuser == ActPush)) begin
          state_d = StHdr;
        end
      end
      StHdr: begin
        cnt_d   = hdr_rd_q.count;
        sq_d    = hdr_rd_q.base;
        idx_d   = '0;
        basex_d = flip_q ?
                  (px0_q + $signed({{(CoordW-PixW){1'b0}}, hdr_rd_q.width}) - $signed(CoordW'(TILE_PX)))
                  : px0_q;
        if (!hit_q || (hdr_rd_q.count == '0)) begin
          state_d = StIdle;
        end else begin
          state_d = StFetch;
        end
      end
      StFetch: begin
        state_d = StEval;
      end
      StEval: begin
        // a new visible square pushes the held one out; wait if the output is busy
        if (!(visible && pend_vld_q && !out_free)) begin
          if (visible) begin
            if (pend_vld_q) begin
              out_d       = pend_q;
              out_last_d  = 1'b0;
              out_layer_d = layer_q;
              out_flip_d  = flip_q;
              out_vld_d   = 1'b1;
            end
            pend_d     = '{x: cur_x[OutPosW-1:0], y: cur_y[OutPosW-1:0], id: sq_q};
            pend_vld_d = 1'b1;
          end
          sq_d  = sq_q + SqIdW'(1);
          idx_d = idx_q + CntW'(1);
          state_d = (idx_d == cnt_q) ? StFlush : StFetch;
        end
      end
      StFlush: begin
        if (!pend_vld_q) begin
          state_d = StIdle;
        end else if (out_free) begin
          out_d       = pend_q;
          out_last_d  = 1'b1;
          out_layer_d = layer_q;
          out_flip_d  = flip_q;
          out_vld_d   = 1'b1;
          pend_vld_d  = 1'b0;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sq_q        <= sq_d;
    idx_q       <= idx_d;
    pend_q      <= pend_d;
    out_q       <= out_d;
    out_last_q  <= out_last_d;
    out_layer_q <= out_layer_d;
    out_flip_q  <= out_flip_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {7'd0, out_flip_q, out_q.id, out_layer_q, out_q.y, out_q.x};

endmodule

FILE: hw/rtl/ssec_checker.sv
// Port-level checks for sprite_square_expand_cull_core, bound to the top level.
// Depends on ssec_pkg.
module ssec_port_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [ssec_pkg::ActionW-1:0]  s_axis_tuser,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ssec_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tlast
);
  import ssec_pkg::*;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // a push always occupies the sequencer past the accepting cycle
  a_push_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == ActPush) |=> !s_axis_tready)
    else $error("input ready right after a push");

  // table writes and unused actions leave the input ready in the next cycle
  a_write_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser != ActPush) |=> s_axis_tready)
    else $error("input stalled after a table write");

  // nothing is offered during reset
  a_reset_quiet: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind sprite_square_expand_cull_core ssec_port_checker u_ssec_checker (.*);

FILE: dv/ssec_checker.sv
// Word layouts for the sprite square expand/cull testbench, and the checker that
// predicts the result words and compares them. Depends on ssec_pkg.
package ssec_dv_pkg;
  import ssec_pkg::*;

  localparam logic [ActionW-1:0] ActUnused = 2'd3;

  typedef struct packed {
    logic [5:0]        pad;
    logic [PixW-1:0]   off_y;
    logic [PixW-1:0]   off_x;
    logic [SqIdW-1:0]  sq_index;
    logic [CntW-1:0]   count;
    logic [SqIdW-1:0]  base;
    logic [PixW-1:0]   width;
    logic              flip;
    logic [LayerW-1:0] layer;
    logic [PosW-1:0]   pos_y;
    logic [PosW-1:0]   pos_x;
    logic [SprIdW-1:0] sprite_id;
  } in_word_t;

  typedef struct packed {
    logic [6:0]         pad;
    logic               flip;
    logic [SqIdW-1:0]   id;
    logic [LayerW-1:0]  layer;
    logic [OutPosW-1:0] y;
    logic [OutPosW-1:0] x;
  } out_word_t;

endpackage

module ssec_checker import ssec_pkg::*, ssec_dv_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]      cfg_wdata_i,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [InDataW-1:0]   s_axis_tdata,
  input  logic [ActionW-1:0]   s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [OutDataW-1:0]  m_axis_tdata,
  input  logic                 m_axis_tlast,
  output int                   fail_count_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [OutPosW-1:0] x;
    logic [OutPosW-1:0] y;
    logic [LayerW-1:0]  layer;
    logic [SqIdW-1:0]   id;
    logic               flip;
    logic               last;
  } square_t;

  logic [CfgW-1:0] view_w, view_h;
  bit              sprite_live [SPRITE_SLOTS];
  hdr_t            sprite_hdr  [SPRITE_SLOTS];
  off_t            sq_offset   [SQUARE_SLOTS];
  square_t         squares_due [$];
  int              n_fail = 0;

  assign fail_count_o = n_fail;

  // expand one push into the visible squares, in square order
  task automatic expand_push(input in_word_t w);
    hdr_t    hdr;
    off_t    off;
    square_t sq;
    int      px0, py0, px, py, xlim, ylim, cnt, n;
    logic [SqIdW-1:0] sid;
    if (!sprite_live[w.sprite_id]) return;
    hdr  = sprite_hdr[w.sprite_id];
    cnt  = int'(hdr.count);
    px0  = (int'($signed(w.pos_x)) * TILE_PX) / 16;
    py0  = (int'($signed(w.pos_y)) * TILE_PX) / 16;
    xlim = (int'(view_w) + 1) * TILE_PX;
    ylim = (int'(view_h) + 1) * TILE_PX;
    n    = 0;
    for (int i = 0; i < cnt; i++) begin
      sid = SqIdW'(int'(hdr.base) + i);
      off = sq_offset[int'(sid) % SQUARE_SLOTS];
      px  = w.flip ? int'(hdr.width) - int'(off.x) - TILE_PX + px0 : px0 + int'(off.x);
      py  = py0 + int'(off.y);
      if (px > -TILE_PX && px < xlim && py > -TILE_PX && py < ylim) begin
        sq.x     = OutPosW'(px);
        sq.y     = OutPosW'(py);
        sq.layer = w.layer;
        sq.id    = sid;
        sq.flip  = w.flip;
        sq.last  = 1'b0;
        squares_due.push_back(sq);
        n++;
      end
    end
    if (n > 0) squares_due[squares_due.size() - 1].last = 1'b1;
  endtask

  task automatic take_word(input logic [ActionW-1:0] act, input in_word_t w);
    hdr_t hdr;
    case (act)
      ActHeader: begin
        hdr.width = w.width;
        hdr.base  = w.base;
        hdr.count = (int'(w.count) > MAX_SQUARES_PER_SPRITE) ?
                    CntW'(MAX_SQUARES_PER_SPRITE) : w.count;
        sprite_hdr[w.sprite_id]  = hdr;
        sprite_live[w.sprite_id] = 1'b1;
      end
      ActOffset: begin
        sq_offset[w.sq_index].x = w.off_x;
        sq_offset[w.sq_index].y = w.off_y;
      end
      ActPush: expand_push(w);
      default: ;
    endcase
  endtask

  task automatic check_square(input out_word_t got, input logic got_last);
    square_t want;
    if (squares_due.size() == 0) begin
      n_fail++;
      if (n_fail <= 10)
        $display("%0t: unexpected square word x=%0d y=%0d layer=%0d id=%0d flip=%0b last=%0b",
                 $realtime, $signed(got.x), $signed(got.y), got.layer, got.id, got.flip,
                 got_last);
      return;
    end
    want = squares_due.pop_front();
    if (got.x !== want.x || got.y !== want.y || got.layer !== want.layer ||
        got.id !== want.id || got.flip !== want.flip || got_last !== want.last) begin
      n_fail++;
      if (n_fail <= 10)
        $display({"%0t: square mismatch: expected x=%0d y=%0d layer=%0d id=%0d flip=%0b ",
                  "last=%0b, got x=%0d y=%0d layer=%0d id=%0d flip=%0b last=%0b"},
                 $realtime, $signed(want.x), $signed(want.y), want.layer, want.id,
                 want.flip, want.last, $signed(got.x), $signed(got.y), got.layer, got.id,
                 got.flip, got_last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_w = CfgW'(20);
      view_h = CfgW'(15);
      foreach (sprite_live[i]) sprite_live[i] = 1'b0;
      squares_due.delete();
      pending_o <= 0;
    end else begin
      // results first: a word accepted now cannot stem from an input taken now
      if (m_axis_tvalid && m_axis_tready) check_square(m_axis_tdata, m_axis_tlast);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgViewWidth:  view_w = cfg_wdata_i;
          CfgViewHeight: view_h = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) take_word(s_axis_tuser, s_axis_tdata);
      pending_o <= squares_due.size();
    end
  end

endmodule

FILE: dv/tb.sv
// Top of the sprite square expand/cull testbench: clock, reset, stimulus and verdict.
// Depends on ssec_pkg, ssec_dv_pkg and ssec_checker.
module tb import ssec_pkg::*, ssec_dv_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ResetCycles   = 11;
  localparam int SettleCycles  = 160;
  localparam int ItemsPerPhase = 75;
  localparam int NumPhases     = 6;

  logic                 clk_i     = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx   = '0;
  logic [CfgW-1:0]      cfg_wdata = '0;
  logic                 s_valid   = 1'b0;
  logic [InDataW-1:0]   s_data    = '0;
  logic [ActionW-1:0]   s_user    = '0;
  logic                 m_ready   = 1'b0;
  logic                 s_ready, m_valid, m_last;
  logic [OutDataW-1:0]  m_data;
  int                   fails, pending;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int words_sent;
  int view_w = 20, view_h = 15;

  // what has been loaded so far, so that no push reads an unwritten offset
  bit          hdr_known [SPRITE_SLOTS];
  logic [7:0]  hdr_base  [SPRITE_SLOTS];
  int          hdr_cnt   [SPRITE_SLOTS];
  bit          off_known [SQUARE_SLOTS];

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) m_ready <= ($urandom_range(99) >= sink_stall_pct);

  sprite_square_expand_cull_core uut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
    .s_axis_tdata(s_data), .s_axis_tuser(s_user),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
    .m_axis_tdata(m_data), .m_axis_tlast(m_last)
  );

  ssec_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_wdata_i(cfg_wdata),
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready),
    .s_axis_tdata(s_data), .s_axis_tuser(s_user),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready),
    .m_axis_tdata(m_data), .m_axis_tlast(m_last),
    .fail_count_o(fails), .pending_o(pending)
  );

  // unused fields carry random bits; the core must ignore them
  function automatic in_word_t noise_word();
    logic [127:0] r;
    in_word_t     w;
    r = {$urandom(), $urandom(), $urandom(), $urandom()};
    w = r[InDataW-1:0];
    w.pad = '0;
    return w;
  endfunction

  function automatic int pick_off();
    return ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(160);
  endfunction

  function automatic int pick_count();
    int r;
    r = $urandom_range(19);
    if (r < 12) return $urandom_range(1, 6);
    if (r < 16) return $urandom_range(16);
    if (r < 19) return $urandom_range(17, 64);
    return $urandom_range(65, 127);
  endfunction

  task automatic put_word(input logic [ActionW-1:0] act, input in_word_t w);
    while ($urandom_range(99) < src_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= act;
    s_data  <= w;
    do @(posedge clk_i); while (!s_ready);
    if (act != ActUnused) words_sent++;
  endtask

  task automatic send_offset(input int idx, input int x, input int y);
    in_word_t w;
    w = noise_word();
    w.sq_index = SqIdW'(idx);
    w.off_x    = PixW'(x);
    w.off_y    = PixW'(y);
    put_word(ActOffset, w);
    off_known[idx] = 1'b1;
  endtask

  task automatic send_header(input int id, input int width, input int base, input int cnt);
    in_word_t w;
    w = noise_word();
    w.sprite_id = SprIdW'(id);
    w.width     = PixW'(width);
    w.base      = SqIdW'(base);
    w.count     = CntW'(cnt);
    put_word(ActHeader, w);
    hdr_known[id] = 1'b1;
    hdr_base[id]  = SqIdW'(base);
    hdr_cnt[id]   = (cnt > MAX_SQUARES_PER_SPRITE) ? MAX_SQUARES_PER_SPRITE : cnt;
  endtask

  task automatic send_push(input int id, input int x, input int y, input int layer,
                           input bit flip);
    in_word_t w;
    int       sq;
    if (hdr_known[id]) begin
      for (int i = 0; i < hdr_cnt[id]; i++) begin
        sq = (int'(hdr_base[id]) + i) % SQUARE_SLOTS;
        if (!off_known[sq]) send_offset(sq, pick_off(), pick_off());
      end
    end
    w = noise_word();
    w.sprite_id = SprIdW'(id);
    w.pos_x     = PosW'(x);
    w.pos_y     = PosW'(y);
    w.layer     = LayerW'(layer);
    w.flip      = flip;
    put_word(ActPush, w);
  endtask

  // mostly near the view, now and then anywhere in the 16-bit range
  task automatic push_random(input int id);
    int x, y;
    if ($urandom_range(9) < 8) begin
      x = $urandom_range(view_w * TILE_PX + 240) - 220;
      y = $urandom_range(view_h * TILE_PX + 240) - 220;
    end else begin
      x = $urandom_range(65535) - 32768;
      y = $urandom_range(65535) - 32768;
    end
    send_push(id, x, y, $urandom_range(255), $urandom_range(1));
  endtask

  task automatic random_item();
    int r, id;
    r  = $urandom_range(99);
    id = $urandom_range(SPRITE_SLOTS - 1);
    if (r < 50) begin
      repeat (8) if (!hdr_known[id]) id = $urandom_range(SPRITE_SLOTS - 1);
      push_random(id);
    end else if (r < 68) begin
      send_header(id, ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(16, 160),
                  $urandom_range(255), pick_count());
      repeat ($urandom_range(1, 3)) push_random(id);
    end else if (r < 85) begin
      send_offset($urandom_range(SQUARE_SLOTS - 1), pick_off(), pick_off());
    end else if (r < 93) begin
      send_header(id, $urandom_range(4095), $urandom_range(255), pick_count());
    end else begin
      put_word(ActUnused, noise_word());
    end
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_view(input int w, input int h);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgViewWidth;
    cfg_wdata <= CfgW'(w);
    @(posedge clk_i);
    cfg_idx   <= CfgViewHeight;
    cfg_wdata <= CfgW'(h);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
    view_w = w;
    view_h = h;
  endtask

  initial begin
    rst_ni <= 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        1: set_view(1, 1);
        2: set_view(255, 255);
        3: set_view(255, 1);
        4: set_view(1, 255);
        5: set_view($urandom_range(2, 254), $urandom_range(2, 254));
        default: ;
      endcase
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 57; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 57; end
        default: begin src_idle_pct = 14; sink_stall_pct = 14; end
      endcase
      if (p == 0) begin
        send_push(5, 0, 0, 0, 1'b0);            // slot never written
        put_word(ActUnused, noise_word());
        send_header(1, 64, 0, 4);
        send_offset(0, 0, 0);
        send_offset(1, 16, 0);
        send_offset(2, 32, 0);
        send_offset(3, 48, 16);
        send_push(1, 0, 0, 0, 1'b0);
        send_push(1, 10, -5, 255, 1'b1);
        send_push(1, -15, -15, 85, 1'b0);        // just inside the left/top margin
        send_push(1, -64, 0, 1, 1'b0);           // all culled, last one on the edge
        send_push(1, 288, 240, 2, 1'b0);         // right/bottom edges
        send_push(1, 32767, -32768, 3, 1'b1);
        send_push(1, -32768, 32767, 4, 1'b0);
        send_header(2, 0, 7, 0);                 // empty sprite
        send_push(2, 0, 0, 5, 1'b0);
        send_header(63, 4095, 250, 127);         // count saturates, ids wrap
        send_push(63, 0, 0, 170, 1'b1);
        send_push(63, -100, 20, 170, 1'b0);
        send_offset(255, 4095, 4095);
        send_push(63, 0, 0, 6, 1'b0);
        send_header(0, 4095, 255, 2);
        send_push(0, -4000, 0, 7, 1'b1);
      end
      words_sent = 0;
      while (words_sent < ItemsPerPhase) random_item();
      drain();
    end
    if (fails == 0)
      $display("sprite_square_expand_cull_core regression: pass");
    else
      $display("sprite_square_expand_cull_core regression: fail");
    $finish;
  end

  initial begin
    #30ms;
    $display("sprite_square_expand_cull_core regression: fail");
    $finish;
  end

endmodule
